FILE: hw/rtl/swa_pkg.sv
// ----------------------------------------------------------------------------
// swa_pkg: shared types and constants of the session window assigner
// payload structs, register map, result queue sizing and time limits
// ----------------------------------------------------------------------------
package swa_pkg;

  localparam int unsigned TIME_W = 63;
  localparam int unsigned ID_W   = 32;
  localparam int unsigned CFG_W  = 32;
  localparam int unsigned ADDR_W = 4;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
  localparam logic [ID_W-1:0]   ID_FIRST = ID_W'(1);

  // register indexes, taken from paddr[3:2]
  localparam logic [1:0] REG_IDLE_TIMEOUT  = 2'd0;
  localparam logic [1:0] REG_MAX_LENGTH    = 2'd1;
  localparam logic [1:0] REG_START_INCL    = 2'd2;
  localparam logic [1:0] REG_END_INCL      = 2'd3;

  // result queue
  localparam int unsigned RQ_DEPTH = 4;
  localparam int unsigned RQ_AW    = $clog2(RQ_DEPTH);
  localparam int unsigned RQ_CW    = $clog2(RQ_DEPTH + 1);

  typedef struct packed {
    logic [TIME_W-1:0] row_time;
    logic              start_flag;
    logic              end_flag;
  } swa_in_t;

  typedef struct packed {
    logic [ID_W-1:0]   assigned_session;
    logic [TIME_W-1:0] window_begin;
    logic [TIME_W-1:0] window_finish;
    logic              final_of_row;
  } swa_out_t;

  typedef struct packed {
    logic [CFG_W-1:0] idle_timeout;
    logic [CFG_W-1:0] max_session_length;
    logic             start_inclusive;
    logic             end_inclusive;
  } swa_cfg_t;

  // results of one row handed to the queue
  typedef struct packed {
    logic [1:0] cnt;
    swa_out_t   first;
    swa_out_t   second;
  } swa_push_t;

endpackage

FILE: hw/rtl/swa_cfg.sv
// ----------------------------------------------------------------------------
// swa_cfg: configuration register file
// apb-style write and read of the four session control registers
// ----------------------------------------------------------------------------
module swa_cfg
  import swa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [CFG_W-1:0]  pwdata,
  output logic [CFG_W-1:0]  prdata,
  output logic              pready,
  output swa_cfg_t          cfg
);

  swa_cfg_t   cfg_r;
  swa_cfg_t   cfg_nxt;
  logic       wr_en;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[3:2];
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_IDLE_TIMEOUT: cfg_nxt.idle_timeout       = pwdata;
        REG_MAX_LENGTH:   cfg_nxt.max_session_length = pwdata;
        REG_START_INCL:   cfg_nxt.start_inclusive    = pwdata[0];
        REG_END_INCL:     cfg_nxt.end_inclusive      = pwdata[0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_IDLE_TIMEOUT: prdata = cfg_r.idle_timeout;
      REG_MAX_LENGTH:   prdata = cfg_r.max_session_length;
      REG_START_INCL:   prdata = {{(CFG_W-1){1'b0}}, cfg_r.start_inclusive};
      REG_END_INCL:     prdata = {{(CFG_W-1){1'b0}}, cfg_r.end_inclusive};
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.idle_timeout       <= '0;
      cfg_r.max_session_length <= '0;
      cfg_r.start_inclusive    <= 1'b1;
      cfg_r.end_inclusive      <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: hw/rtl/swa_core.sv
// ----------------------------------------------------------------------------
// swa_core: session state and per-row assignment
// one row per step: close checks, optional reopen, up to two results
// ----------------------------------------------------------------------------
module swa_core
  import swa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  swa_in_t   row,
  input  swa_cfg_t  cfg,
  output swa_push_t push
);

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic              have;
    logic              act;
    logic              used;
    logic [TIME_W-1:0] wb;
    logic [TIME_W-1:0] wf;
    logic [TIME_W-1:0] idl;
    logic [TIME_W-1:0] szd;
  } sess_t;

  sess_t             sess_r;
  sess_t             sess_nxt;
  sess_t             s;
  logic [TIME_W-1:0] t;
  logic              closed;
  logic              live;
  logic              do_open;
  logic [1:0]        k;
  swa_out_t          r0;
  swa_out_t          r1;

  // saturating time sum
  function automatic logic [TIME_W-1:0] sat_add(logic [TIME_W-1:0] a, logic [CFG_W-1:0] b);
    logic [TIME_W:0] sum;
    sum = {1'b0, a} + {{(TIME_W+1-CFG_W){1'b0}}, b};
    return sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
  endfunction

  function automatic sess_t absorb_row(sess_t st, logic [TIME_W-1:0] tm, logic [CFG_W-1:0] to);
    sess_t n;
    n = st;
    if (!st.used) begin
      n.wb   = tm;
      n.used = 1'b1;
    end
    if (tm >= st.wf) begin
      n.wf  = sat_add(tm, CFG_W'(1));
      n.idl = sat_add(tm, to);
    end
    return n;
  endfunction

  // an empty session hands its id and bounds on
  function automatic sess_t open_sess(sess_t st, logic [TIME_W-1:0] tm, swa_cfg_t c);
    sess_t           n;
    logic [ID_W-1:0] nid;
    n   = st;
    nid = st.have ? st.id + ID_FIRST : ID_FIRST;
    if (nid == '0) begin
      nid = ID_FIRST;
    end
    if (!st.have || st.used) begin
      n.id   = nid;
      n.have = 1'b1;
      n.used = 1'b0;
      n.wb   = '0;
      n.wf   = '0;
    end
    n.act = 1'b1;
    n.idl = sat_add(tm, c.idle_timeout);
    n.szd = sat_add(tm, c.max_session_length);
    return n;
  endfunction

  function automatic swa_out_t emit(sess_t st);
    swa_out_t o;
    o.assigned_session = st.id;
    o.window_begin     = st.wb;
    o.window_finish    = st.wf;
    o.final_of_row     = 1'b0;
    return o;
  endfunction

  assign t    = row.row_time;
  assign live = sess_r.have && sess_r.act;

  always_comb begin
    s      = sess_r;
    k      = 2'd0;
    r0     = '0;
    r1     = '0;
    closed = 1'b0;
    if (live) begin
      closed = 1'b1;
      if (t >= s.szd) begin
        s.wf  = s.szd;
        s.act = 1'b0;
      end else if (t >= s.idl) begin
        s.wf  = s.idl;
        s.act = 1'b0;
      end else if (row.end_flag) begin
        if (cfg.end_inclusive) begin
          s  = absorb_row(s, t, cfg.idle_timeout);
          r0 = emit(s);
          k  = 2'd1;
        end else if (t > s.wf) begin
          s.wf = t;
        end
        s.act = 1'b0;
      end else begin
        closed = 1'b0;
        s      = absorb_row(s, t, cfg.idle_timeout);
        r0     = emit(s);
        k      = 2'd1;
      end
    end
    do_open = row.start_flag && (!live || closed);
    if (do_open) begin
      s = open_sess(s, t, cfg);
      if (cfg.start_inclusive) begin
        s = absorb_row(s, t, cfg.idle_timeout);
        if (k == 2'd0) begin
          r0 = emit(s);
        end else begin
          r1 = emit(s);
        end
        k = k + 2'd1;
      end
    end
    // mark the last result of the row
    if (k == 2'd1) begin
      r0.final_of_row = 1'b1;
    end
    if (k == 2'd2) begin
      r1.final_of_row = 1'b1;
    end
    sess_nxt = s;
  end

  assign push.cnt    = step ? k : 2'd0;
  assign push.first  = r0;
  assign push.second = r1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sess_r <= '0;
    end else if (step) begin
      sess_r <= sess_nxt;
    end
  end

endmodule

FILE: hw/rtl/swa_fifo.sv
// ----------------------------------------------------------------------------
// swa_fifo: result queue
// takes zero, one or two results per cycle and, while out_stall is low, hands out one beat per cycle
// ----------------------------------------------------------------------------
module swa_fifo
  import swa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  swa_push_t push,
  output logic      room,
  output logic      out_valid,
  input  logic      out_stall,
  output swa_out_t  out_data
);

  swa_out_t         mem [RQ_DEPTH];
  logic [RQ_AW-1:0] wr_ptr_r;
  logic [RQ_AW-1:0] wr_ptr_nxt;
  logic [RQ_AW-1:0] rd_ptr_r;
  logic [RQ_AW-1:0] rd_ptr_nxt;
  logic [RQ_CW-1:0] count_r;
  logic [RQ_CW-1:0] count_nxt;
  logic             pop;

  assign out_valid = (count_r != '0);
  assign out_data  = mem[rd_ptr_r];
  assign pop       = out_valid && !out_stall;
  // space for the two results a row may give
  assign room      = (count_r <= RQ_CW'(RQ_DEPTH - 2));

  assign wr_ptr_nxt = wr_ptr_r + RQ_AW'(push.cnt);
  assign rd_ptr_nxt = rd_ptr_r + RQ_AW'(pop);
  assign count_nxt  = count_r + RQ_CW'(push.cnt) - RQ_CW'(pop);

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wr_ptr_r] <= push.first;
    end
    if (push.cnt == 2'd2) begin
      mem[wr_ptr_r + RQ_AW'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

FILE: hw/rtl/session_window_assigner.sv
// ----------------------------------------------------------------------------
// session_window_assigner: streaming session window assignment
// rows in, session id and window bounds out, one apb-style register port
// ----------------------------------------------------------------------------
// usage
//   in_valid/in_stall/in_data carry one row per beat (event time, start and
//   end flags); out_valid/out_stall/out_data carry one result per beat.
//   a row gives zero, one or two results; final_of_row marks the last one.
//   psel/penable/pwrite/paddr/pwdata/prdata/pready write and read the idle
//   timeout, maximum length and the two inclusive bits at 0x0, 0x4, 0x8, 0xc;
//   change them only while no row is in flight.
// path: a row accepted into the row stage is processed from there by the core,
//   which writes its results into the result queue that drives out_data.
// throughput: one row per cycle as long as rows give at most one result and
//   out_stall stays low; the single result port sets the rate, so a two-result
//   row leaves as two beats, and the row stage waits while under two entries are free.
// reset (rst_n low, synchronous): no session, empty queue, timeouts 0,
//   both inclusive bits 1.
// out_stall: results build up in a four-entry queue; once fewer than two
//   free entries remain the held row waits and in_stall rises.
// ----------------------------------------------------------------------------
module session_window_assigner
  import swa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // row channel
  input  logic              in_valid,
  output logic              in_stall,
  input  swa_in_t           in_data,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output swa_out_t          out_data,
  // register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [CFG_W-1:0]  pwdata,
  output logic [CFG_W-1:0]  prdata,
  output logic              pready
);

  swa_cfg_t  cfg;
  swa_push_t push;
  swa_in_t   stg_r;
  logic      stg_vld_r;
  logic      stg_vld_nxt;
  logic      room;
  logic      proceed;
  logic      accept;

  // register file
  swa_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // row stage: holds the accepted beat until the queue can take its results
  assign proceed     = stg_vld_r && room;
  assign in_stall    = stg_vld_r && !room;
  assign accept      = in_valid && !in_stall;
  assign stg_vld_nxt = accept ? 1'b1 : (proceed ? 1'b0 : stg_vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
    end else begin
      stg_vld_r <= stg_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stg_r <= in_data;
    end
  end

  // session state update and result forming, one row per step
  swa_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (proceed),
    .row   (stg_r),
    .cfg   (cfg),
    .push  (push)
  );

  // result queue in front of the output port
  swa_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // a held row keeps its contents until it is processed
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    stg_vld_r && !room |=> stg_vld_r && $stable(stg_r))
    else $error("row stage lost or changed a waiting row");

  // only opened sessions produce results, so the id is never zero
  a_id_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.assigned_session != '0)
    else $error("result with session id zero");

  // with two results only the second closes the row
  a_final_mark: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt == 2'd2 |-> !push.first.final_of_row && push.second.final_of_row)
    else $error("final_of_row misplaced on a two-result row");

  // a row whose results are pushed must have been waiting in the stage
  a_push_src: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt != 2'd0 |-> $past(stg_vld_nxt) && room)
    else $error("results pushed without a held row");
`endif

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: session window assigner
// drives rows through the valid/stall row channel, predicts every result from
// its own model of the session record and compares beats in order; a short
// directed table comes first, then random phases with different register
// settings and different idle and stall patterns on both channels
// ----------------------------------------------------------------------------
module testbench;
  import swa_pkg::*;

  localparam int unsigned CLK_HALF       = 4;
  localparam int unsigned RESET_CYCLES   = 11;
  localparam int unsigned SETTLE_CYCLES  = 8;       // row stage plus result queue
  localparam int unsigned CYCLE_LIMIT    = 200000;
  localparam int unsigned PHASES         = 8;
  localparam int unsigned ROWS_PER_PHASE = 75;

  // how a directed row is checked: by the predictor, as giving nothing,
  // or against one result typed into the table
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_ONE} row_check_t;
  typedef enum logic {STEP_ROW, STEP_REG} step_kind_t;

  typedef struct {
    step_kind_t       kind;
    logic [1:0]       reg_idx;
    logic [CFG_W-1:0] reg_val;
    swa_in_t          row;
    row_check_t       chk;
    swa_out_t         want;
  } step_t;

  // --------------------------------------------------------------------------
  // clock, reset and block pins
  // --------------------------------------------------------------------------
  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  swa_in_t           in_data   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  swa_out_t          out_data;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [ADDR_W-1:0] paddr     = '0;
  logic [CFG_W-1:0]  pwdata    = '0;
  logic [CFG_W-1:0]  prdata;
  logic              pready;

  // side band that travels with each row beat, sampled at the same edge
  row_check_t        row_chk   = CHK_MODEL;
  swa_out_t          row_want  = '0;

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  session_window_assigner dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // --------------------------------------------------------------------------
  // session predictor: one session record plus the register copies,
  // all starting at their reset values
  // --------------------------------------------------------------------------
  logic [CFG_W-1:0]  cfg_idle       = '0;
  logic [CFG_W-1:0]  cfg_max_len    = '0;
  logic              cfg_start_incl = 1'b1;
  logic              cfg_end_incl   = 1'b1;

  logic [ID_W-1:0]   sess_id   = '0;
  logic              sess_open = 1'b0;   // some session was ever opened
  logic              sess_live = 1'b0;   // current session still accepts rows
  logic              sess_kept = 1'b0;   // current session holds at least one row
  logic [TIME_W-1:0] win_lo    = '0;
  logic [TIME_W-1:0] win_hi    = '0;
  logic [TIME_W-1:0] idle_dl   = '0;
  logic [TIME_W-1:0] size_dl   = '0;

  swa_out_t row_res[$];           // results of the row being predicted
  swa_out_t pending_results[$];   // results still owed by the block
  step_t    directed_steps[$];

  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;
  int unsigned row_gap_pct = 0;   // sender idle share, percent
  int unsigned hold_pct    = 0;   // receiver stall share, percent

  // time plus a register value, pinned at the top of the time range
  function automatic logic [TIME_W-1:0] tick_sum(input logic [TIME_W-1:0] t,
                                                 input logic [CFG_W-1:0] d);
    logic [TIME_W:0] s;
    s = {1'b0, t} + {{(TIME_W + 1 - CFG_W){1'b0}}, d};
    return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
  endfunction

  // row joins the current session; extends the window when it lies past it
  task automatic take_row(input logic [TIME_W-1:0] t);
    swa_out_t r;
    if (!sess_kept) begin
      win_lo    = t;
      sess_kept = 1'b1;
    end
    if (t >= win_hi) begin
      win_hi  = tick_sum(t, CFG_W'(1));
      idle_dl = tick_sum(t, cfg_idle);
    end
    r.assigned_session = sess_id;
    r.window_begin     = win_lo;
    r.window_finish    = win_hi;
    r.final_of_row     = 1'b0;
    row_res.insert(row_res.size(), r);
  endtask

  // a session with no rows hands its id and bounds on to the new one
  task automatic start_session(input logic [TIME_W-1:0] t);
    if (!sess_open || sess_kept) begin
      sess_id   = sess_open ? sess_id + ID_W'(1) : ID_FIRST;
      if (sess_id == '0)
        sess_id = ID_FIRST;
      sess_open = 1'b1;
      sess_kept = 1'b0;
      win_lo    = '0;
      win_hi    = '0;
    end
    sess_live = 1'b1;
    idle_dl   = tick_sum(t, cfg_idle);
    size_dl   = tick_sum(t, cfg_max_len);
    if (cfg_start_incl)
      take_row(t);
  endtask

  task automatic predict_row(input swa_in_t r);
    logic [TIME_W-1:0] t;
    logic              closed;
    swa_out_t          last;
    t = r.row_time;
    row_res.delete();
    if (sess_open && sess_live) begin
      // close order: size deadline, idle deadline, end condition
      closed = 1'b1;
      if (t >= size_dl) begin
        win_hi    = size_dl;
        sess_live = 1'b0;
      end else if (t >= idle_dl) begin
        win_hi    = idle_dl;
        sess_live = 1'b0;
      end else if (r.end_flag) begin
        if (cfg_end_incl)
          take_row(t);
        else if (t > win_hi)
          win_hi = t;
        sess_live = 1'b0;
      end else begin
        closed = 1'b0;
      end
      if (!closed)
        take_row(t);
      else if (r.start_flag)
        start_session(t);
    end else if (r.start_flag) begin
      start_session(t);
    end
    if (row_res.size() != 0) begin
      last = row_res.pop_back();
      last.final_of_row = 1'b1;
      row_res.insert(row_res.size(), last);
    end
  endtask

  // --------------------------------------------------------------------------
  // result checking
  // --------------------------------------------------------------------------
  task automatic field_check(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_result(input swa_out_t got);
    swa_out_t want;
    if (pending_results.size() == 0) begin
      $error("result beat with nothing owed: session %0d begin %0d finish %0d",
             got.assigned_session, got.window_begin, got.window_finish);
      fail_count++;
    end else begin
      want = pending_results[0];
      pending_results.delete(0);
      field_check("assigned_session", 64'(want.assigned_session),
                  64'(got.assigned_session));
      field_check("window_begin", 64'(want.window_begin), 64'(got.window_begin));
      field_check("window_finish", 64'(want.window_finish), 64'(got.window_finish));
      field_check("final_of_row", 64'(want.final_of_row), 64'(got.final_of_row));
    end
  endtask

  // both channels are sampled at the edge; all drives are nonblocking, so the
  // values seen here are the ones that held just before the edge
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      check_result(out_data);
    if (rst_n && in_valid && !in_stall) begin
      predict_row(in_data);
      case (row_chk)
        CHK_NONE: begin
        end
        CHK_ONE: begin
          pending_results.insert(pending_results.size(), row_want);
        end
        default: begin
          foreach (row_res[i])
            pending_results.insert(pending_results.size(), row_res[i]);
        end
      endcase
    end
  end

  // receiver: random stall at the share set by the current phase
  always @(posedge clk) begin
    out_stall <= (hold_pct != 0) && ($urandom_range(0, 99) < hold_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $error("no finish after %0d cycles, %0d results still owed",
             CYCLE_LIMIT, pending_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------
  // optional idle cycles, then one row beat held until it is taken
  task automatic send_row(input swa_in_t r, input row_check_t chk,
                          input swa_out_t want);
    while (row_gap_pct != 0 && $urandom_range(0, 99) < row_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    row_chk  <= chk;
    row_want <= want;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
  endtask

  // stop sending and wait until every owed result has come back, then let
  // rows that give no result leave the pipeline as well
  task automatic drain_results();
    in_valid <= 1'b0;
    // wait for the clock first so the last accepted row is already predicted
    @(posedge clk);
    while (pending_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // setup cycle, access cycle; the register takes the value at the access edge
  task automatic cfg_write(input logic [1:0] idx, input logic [CFG_W-1:0] val);
    logic [CFG_W-1:0] rd_want;
    rd_want = val;
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready)
      @(posedge clk);
    case (idx)
      REG_IDLE_TIMEOUT: cfg_idle       = val;
      REG_MAX_LENGTH:   cfg_max_len    = val;
      REG_START_INCL: begin
        cfg_start_incl = val[0];
        rd_want        = {{(CFG_W-1){1'b0}}, val[0]};
      end
      REG_END_INCL: begin
        cfg_end_incl = val[0];
        rd_want      = {{(CFG_W-1){1'b0}}, val[0]};
      end
      default: begin
      end
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    // address still held: read back what was just written
    field_check("prdata", 64'(rd_want), 64'(prdata));
  endtask

  function automatic step_t row_step(input logic [TIME_W-1:0] t, input logic s,
                                     input logic e, input row_check_t chk,
                                     input logic [ID_W-1:0] id,
                                     input logic [TIME_W-1:0] lo,
                                     input logic [TIME_W-1:0] hi);
    step_t st;
    st.kind                  = STEP_ROW;
    st.reg_idx               = '0;
    st.reg_val               = '0;
    st.row.row_time          = t;
    st.row.start_flag        = s;
    st.row.end_flag          = e;
    st.chk                   = chk;
    st.want.assigned_session = id;
    st.want.window_begin     = lo;
    st.want.window_finish    = hi;
    st.want.final_of_row     = 1'b1;
    return st;
  endfunction

  function automatic step_t reg_step(input logic [1:0] idx,
                                     input logic [CFG_W-1:0] val);
    step_t st;
    st.kind    = STEP_REG;
    st.reg_idx = idx;
    st.reg_val = val;
    st.row     = '0;
    st.chk     = CHK_MODEL;
    st.want    = '0;
    return st;
  endfunction

  function automatic void add_step(input step_t st);
    directed_steps.insert(directed_steps.size(), st);
  endfunction

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    swa_in_t           r;
    logic [TIME_W-1:0] t_now;
    logic [TIME_W-1:0] hop;
    int unsigned       span;

    // registers at reset: no timeouts, both inclusive bits set
    // first row opens session 1
    add_step(row_step(10, 1, 0, CHK_ONE, 1, 10, 11));
    // zero size limit: next row closes the window at the deadline, gives nothing
    add_step(row_step(12, 0, 0, CHK_NONE, 0, 0, 0));
    // end condition with no live session is ignored
    add_step(row_step(13, 0, 1, CHK_NONE, 0, 0, 0));
    add_step(row_step(13, 1, 1, CHK_ONE, 2, 13, 14));
    // top of the time range: finish saturates instead of wrapping
    add_step(row_step(TIME_MAX, 1, 1, CHK_ONE, 3, TIME_MAX, TIME_MAX));
    // widest timeouts
    add_step(reg_step(REG_IDLE_TIMEOUT, '1));
    add_step(reg_step(REG_MAX_LENGTH, '1));
    // time going backwards: row is kept, window unchanged, no error
    add_step(row_step(0, 1, 0, CHK_ONE, 3, TIME_MAX, TIME_MAX));
    add_step(row_step(TIME_MAX - 5, 0, 1, CHK_ONE, 3, TIME_MAX, TIME_MAX));
    // deadline sums saturate
    add_step(row_step(TIME_MAX - 5, 1, 0, CHK_ONE, 4, TIME_MAX - 5, TIME_MAX - 4));
    // exclusive opening and closing rows
    add_step(reg_step(REG_IDLE_TIMEOUT, 5));
    add_step(reg_step(REG_MAX_LENGTH, 20));
    add_step(reg_step(REG_START_INCL, 0));
    add_step(reg_step(REG_END_INCL, 0));
    add_step(row_step(100, 0, 1, CHK_NONE, 0, 0, 0));
    add_step(row_step(100, 1, 0, CHK_NONE, 0, 0, 0));
    add_step(row_step(103, 0, 1, CHK_NONE, 0, 0, 0));
    // session 5 never kept a row: reopening keeps its id and its finish
    add_step(row_step(104, 1, 0, CHK_NONE, 0, 0, 0));
    add_step(row_step(106, 0, 0, CHK_ONE, 5, 106, 107));
    // end and start on one row: two results
    add_step(reg_step(REG_START_INCL, 1));
    add_step(reg_step(REG_END_INCL, 1));
    add_step(row_step(108, 1, 1, CHK_MODEL, 0, 0, 0));
    // idle close followed by a reopen, then size beats idle
    add_step(row_step(115, 1, 0, CHK_MODEL, 0, 0, 0));
    add_step(row_step(200, 0, 0, CHK_MODEL, 0, 0, 0));

    rst_n <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_steps[i]) begin
      if (directed_steps[i].kind == STEP_REG) begin
        drain_results();
        cfg_write(directed_steps[i].reg_idx, directed_steps[i].reg_val);
      end else begin
        send_row(directed_steps[i].row, directed_steps[i].chk, directed_steps[i].want);
      end
    end

    // random phases; each starts from an idle block with new register values
    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      case (p)
        0: begin
          cfg_write(REG_IDLE_TIMEOUT, '1);
          cfg_write(REG_MAX_LENGTH, '1);
          cfg_write(REG_START_INCL, 0);
          cfg_write(REG_END_INCL, 0);
        end
        1: begin
          cfg_write(REG_IDLE_TIMEOUT, 0);
          cfg_write(REG_MAX_LENGTH, 0);
          cfg_write(REG_START_INCL, 1);
          cfg_write(REG_END_INCL, 0);
        end
        default: begin
          cfg_write(REG_IDLE_TIMEOUT,
                    ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 40));
          cfg_write(REG_MAX_LENGTH,
                    ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 150));
          cfg_write(REG_START_INCL, $urandom_range(0, 1));
          cfg_write(REG_END_INCL, $urandom_range(0, 1));
        end
      endcase

      // idle pattern of this phase
      case (p % 4)
        0: begin row_gap_pct = 0;  hold_pct = 0;  end
        1: begin row_gap_pct = 67; hold_pct = 0;  end
        2: begin row_gap_pct = 0;  hold_pct = 67; end
        default: begin row_gap_pct = 12; hold_pct = 12; end
      endcase

      // time base anywhere in range, often just under the top
      if ($urandom_range(0, 3) == 0)
        t_now = TIME_MAX - TIME_W'($urandom_range(0, 400));
      else
        t_now = TIME_W'({$urandom, $urandom});
      // step size on the scale of the idle timeout so sessions both live and expire
      span = (cfg_idle > 40) ? 40 : cfg_idle;

      for (int n = 0; n < ROWS_PER_PHASE; n++) begin
        if ($urandom_range(0, 9) == 0) begin
          // noise: a jump anywhere, or a small step back in time
          if ($urandom_range(0, 1) == 0)
            r.row_time = TIME_W'({$urandom, $urandom});
          else
            r.row_time = t_now - TIME_W'($urandom_range(0, 20));
          r.start_flag = 1'($urandom);
          r.end_flag   = 1'($urandom);
        end else begin
          hop   = TIME_W'($urandom_range(0, span + span / 2 + 2));
          t_now = (TIME_MAX - t_now < hop) ? TIME_MAX : t_now + hop;
          r.row_time   = t_now;
          r.start_flag = ($urandom_range(0, 99) < 35);
          r.end_flag   = ($urandom_range(0, 99) < 15);
        end
        send_row(r, CHK_MODEL, '0);
      end
    end

    drain_results();
    if (fail_count == 0 && pending_results.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
